### src/ogii_pkg.sv
`default_nettype none
package ogii_pkg;
	localparam int NCH    = 8;
	localparam int PIX_W  = 8;
	localparam int RSUM_W = 17;
	localparam int INT_W  = 26;
	localparam int OUT_W  = 25;
	localparam int CFG_W  = 9;
	localparam int ROW_OUT_W = 8;
	localparam int COL_OUT_W = 9;

	localparam logic CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	typedef logic [RSUM_W-1:0] rsum_arr_t [NCH];
endpackage
`default_nettype wire

### src/ogii_ram.sv
`default_nettype none
module ogii_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

### src/oriented_gradient_integral_image.sv
`default_nettype none
// Streams 8-bit pixels in row-major order and returns the summed-area table of eight
// half-wave gradient channels (dx, dy and both diagonals, negative and positive halves),
// one row and one column late. One pixel is taken per clock while out_stall lets the
// pipeline advance. The exception is the last pixel of each row after the first row of
// an image, which yields two entries, so in_stall holds off the next pixel while the
// second entry is issued; this is set by the single read port of the integral-row
// memory. Each entry is registered in the issue stage and the gradient stage before it
// reaches the output. Pixel lines and the previous integral row live in two RAMs with
// registered reads; running row sums are registers. No clearing pass after reset.
module oriented_gradient_integral_image #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_wr_en,
	input  wire logic                                  cfg_index,
	input  wire logic [ogii_pkg::CFG_W-1:0]            cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [ogii_pkg::PIX_W-1:0]            pixel,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [ogii_pkg::OUT_W-1:0]                 sum_neg_dx,
	output logic [ogii_pkg::OUT_W-1:0]                 sum_pos_dx,
	output logic [ogii_pkg::OUT_W-1:0]                 sum_neg_dy,
	output logic [ogii_pkg::OUT_W-1:0]                 sum_pos_dy,
	output logic [ogii_pkg::OUT_W-1:0]                 sum_neg_du,
	output logic [ogii_pkg::OUT_W-1:0]                 sum_pos_du,
	output logic [ogii_pkg::OUT_W-1:0]                 sum_neg_dv,
	output logic [ogii_pkg::OUT_W-1:0]                 sum_pos_dv,
	output logic [ogii_pkg::ROW_OUT_W-1:0]             out_row,
	output logic [ogii_pkg::COL_OUT_W-1:0]             out_col,
	output logic                                       last_of_step
);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int PW = ogii_pkg::PIX_W;
	localparam int NCH = ogii_pkg::NCH;
	localparam int IW = ogii_pkg::INT_W;
	localparam int SW = ogii_pkg::RSUM_W;
	localparam int CFW = ogii_pkg::CFG_W;
	localparam int BW = (CW > CFW) ? CW : CFW;
	localparam int BH = (RW > CFW) ? RW : CFW;

	logic [CFW-1:0] width_q, height_q;
	logic [CW-1:0]  w;
	logic [RW-1:0]  h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFW'(256);
			height_q <= CFW'(256);
		end else if (cfg_wr_en) begin
			if (cfg_index == ogii_pkg::CFG_IMAGE_WIDTH) begin
				width_q <= cfg_data;
			end else begin
				height_q <= cfg_data;
			end
		end
	end

	// clamp sizes to [3, MAX]
	always_comb begin
		if (BW'(width_q) < BW'(3)) w = CW'(3);
		else if (BW'(width_q) > BW'(MAX_WIDTH)) w = CW'(MAX_WIDTH);
		else w = CW'(width_q);
		if (BH'(height_q) < BH'(3)) h = RW'(3);
		else if (BH'(height_q) > BH'(MAX_HEIGHT)) h = RW'(MAX_HEIGHT);
		else h = RW'(height_q);
	end

	logic adv;
	logic v_s2;
	assign adv = !v_s2 || !out_stall;

	// ---------------- issue stage ----------------
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          extra_q;
	logic [RW-1:0] extra_row_q;
	logic [CW-1:0] c0_c;
	logic [RW-1:0] rr0_c;
	logic [CW-1:0] cn_c;
	logic [RW-1:0] rn_c;
	logic          take;

	assign in_stall = !adv || extra_q;
	assign take     = in_valid && adv && !extra_q;

	always_comb begin
		if (col_q >= w) begin
			c0_c  = '0;
			rr0_c = row_q + RW'(1);
		end else begin
			c0_c  = col_q;
			rr0_c = row_q;
		end
		if (rr0_c >= h) rr0_c = '0;
		cn_c = c0_c + CW'(1);
		rn_c = rr0_c;
		if (cn_c >= w) begin
			cn_c = '0;
			rn_c = rr0_c + RW'(1);
			if (rn_c >= h) rn_c = '0;
		end
	end

	logic          v_s1, extra_s1, emit_s1, last_s1;
	logic [RW-1:0] r_s1;
	logic [CW-1:0] c_s1;
	logic [PW-1:0] pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			extra_q <= 1'b0;
			v_s1    <= 1'b0;
		end else if (adv) begin
			if (extra_q) begin
				extra_q <= 1'b0;
				v_s1    <= 1'b1;
			end else if (in_valid) begin
				col_q   <= cn_c;
				row_q   <= rn_c;
				extra_q <= (rr0_c != '0) && (c0_c == w - CW'(1));
				v_s1    <= 1'b1;
			end else begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (extra_q) begin
				extra_s1 <= 1'b1;
				emit_s1  <= 1'b1;
				last_s1  <= 1'b1;
				r_s1     <= extra_row_q;
				c_s1     <= w;
			end else begin
				extra_s1    <= 1'b0;
				emit_s1     <= (rr0_c != '0) && (c0_c != '0);
				last_s1     <= (c0_c != w - CW'(1));
				r_s1        <= rr0_c;
				c_s1        <= c0_c;
				pix_s1      <= pixel;
				extra_row_q <= rr0_c;
			end
		end
	end

	// pixel lines: entry holds {row r-1, row r} pixels of its column
	logic [2*PW-1:0] line_rd;
	logic            line_we;
	assign line_we = adv && v_s1 && !extra_s1;

	ogii_ram #(.WIDTH(2 * PW), .DEPTH(MAX_WIDTH)) u_line_ram (
		.clk     (clk),
		.wr_en   (line_we),
		.wr_addr (c_s1[AW-1:0]),
		.wr_data ({line_rd[PW-1:0], pix_s1}),
		.rd_en   (take),
		.rd_addr (c0_c[AW-1:0]),
		.rd_data (line_rd)
	);

	// ---------------- gradient stage ----------------
	logic [PW-1:0] top1_q, top2_q, mid1_q, mid2_q, cur1_q, cur2_q;
	ogii_pkg::rsum_arr_t rs_q, rs_next;
	logic [PW-1:0] top_c, mid_c;

	assign top_c = line_rd[2*PW-1:PW];
	assign mid_c = line_rd[PW-1:0];

	always_comb begin
		logic signed [PW+1:0] g [4];
		logic [PW-1:0]        mag;
		logic [PW:0]          nh, ph;
		logic                 inner;
		inner = (r_s1 >= RW'(2)) && (c_s1 >= CW'(2));
		g[0] = $signed({2'b00, mid_c})  - $signed({2'b00, mid2_q});
		g[1] = $signed({2'b00, cur1_q}) - $signed({2'b00, top1_q});
		g[2] = $signed({2'b00, top_c})  - $signed({2'b00, cur2_q});
		g[3] = $signed({2'b00, pix_s1}) - $signed({2'b00, top2_q});
		for (int i = 0; i < 4; i++) begin
			mag = g[i][PW+1] ? PW'(-g[i]) : PW'(g[i]);
			nh = '0;
			ph = '0;
			if (inner) begin
				if (g[i][PW+1]) nh = {mag, 1'b0};
				else ph = {mag, 1'b0};
			end
			rs_next[2*i]   = ((c_s1 == CW'(1)) ? SW'(0) : rs_q[2*i])   + SW'(nh);
			rs_next[2*i+1] = ((c_s1 == CW'(1)) ? SW'(0) : rs_q[2*i+1]) + SW'(ph);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) rs_q[i] <= '0;
		end else if (adv && v_s1 && !extra_s1 && emit_s1) begin
			rs_q <= rs_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1 && !extra_s1) begin
			cur2_q <= cur1_q;
			cur1_q <= pix_s1;
			mid2_q <= mid1_q;
			mid1_q <= mid_c;
			top2_q <= top1_q;
			top1_q <= top_c;
		end
	end

	logic [RW-1:0] r_s2;
	logic [CW-1:0] c_s2;
	logic          last_s2;
	ogii_pkg::rsum_arr_t rs_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s2    <= r_s1;
			c_s2    <= c_s1;
			last_s2 <= last_s1;
			rs_s2   <= extra_s1 ? rs_q : rs_next;
		end
	end

	// ---------------- integral stage ----------------
	logic [NCH*IW-1:0] int_rd, int_wr;
	logic [CW-1:0]     rd_col_c, wr_col_c;
	logic [IW-1:0]     sum_c [NCH];

	assign rd_col_c = c_s1 - CW'(1);
	assign wr_col_c = c_s2 - CW'(1);

	always_comb begin
		logic [IW-1:0] above;
		for (int i = 0; i < NCH; i++) begin
			above = (r_s2 == RW'(1)) ? '0 : int_rd[i*IW +: IW];
			sum_c[i] = above + IW'(rs_s2[i]);
			int_wr[i*IW +: IW] = sum_c[i];
		end
	end

	ogii_ram #(.WIDTH(NCH * IW), .DEPTH(MAX_WIDTH)) u_int_ram (
		.clk     (clk),
		.wr_en   (adv && v_s2),
		.wr_addr (wr_col_c[AW-1:0]),
		.wr_data (int_wr),
		.rd_en   (adv),
		.rd_addr (rd_col_c[AW-1:0]),
		.rd_data (int_rd)
	);

	assign out_valid    = v_s2;
	assign sum_neg_dx   = sum_c[0][ogii_pkg::OUT_W-1:0];
	assign sum_pos_dx   = sum_c[1][ogii_pkg::OUT_W-1:0];
	assign sum_neg_dy   = sum_c[2][ogii_pkg::OUT_W-1:0];
	assign sum_pos_dy   = sum_c[3][ogii_pkg::OUT_W-1:0];
	assign sum_neg_du   = sum_c[4][ogii_pkg::OUT_W-1:0];
	assign sum_pos_du   = sum_c[5][ogii_pkg::OUT_W-1:0];
	assign sum_neg_dv   = sum_c[6][ogii_pkg::OUT_W-1:0];
	assign sum_pos_dv   = sum_c[7][ogii_pkg::OUT_W-1:0];
	assign out_row      = ogii_pkg::ROW_OUT_W'(r_s2);
	assign out_col      = ogii_pkg::COL_OUT_W'(c_s2);
	assign last_of_step = last_s2;
endmodule
`default_nettype wire

### sim/tb_oriented_gradient_integral_image.sv
`default_nettype none
module tb_oriented_gradient_integral_image;
	import ogii_pkg::*;

	localparam int MAXW = 256;
	localparam int MAXH = 256;

	typedef struct packed {
		logic [NCH-1:0][OUT_W-1:0] sums;
		logic [ROW_OUT_W-1:0]      row;
		logic [COL_OUT_W-1:0]      col;
		logic                      last;
	} entry_t;

	class grad_integral_scoreboard;
		logic [CFG_W-1:0]  width_reg;
		logic [CFG_W-1:0]  height_reg;
		logic [PIX_W-1:0]  lines [3][MAXW];
		logic [RSUM_W-1:0] row_sums [NCH];
		logic [INT_W-1:0]  int_row [NCH][MAXW];
		int                row_pos;
		int                col_pos;
		int                errors;
		entry_t            pending_entries [$];

		function new();
			width_reg = 256;
			height_reg = 256;
			row_pos = 0;
			col_pos = 0;
			errors = 0;
			foreach (row_sums[i]) row_sums[i] = '0;
		endfunction

		function int clamp_size(int v, int maxv);
			if (v < 3) return 3;
			if (v > maxv) return maxv;
			return v;
		endfunction

		function int cur_width();
			return clamp_size(width_reg, MAXW);
		endfunction

		function int pix(int row, int col);
			return int'(lines[row % 3][col]);
		endfunction

		function void post_entry(int r, int col, bit last);
			entry_t e;
			logic [INT_W-1:0] above;
			logic [INT_W-1:0] v;
			for (int ch = 0; ch < NCH; ch++) begin
				above = (r == 1) ? '0 : int_row[ch][col-1];
				v = above + INT_W'(row_sums[ch]);
				int_row[ch][col-1] = v;
				e.sums[ch] = v[OUT_W-1:0];
			end
			e.row = ROW_OUT_W'(r);
			e.col = COL_OUT_W'(col);
			e.last = last;
			pending_entries.push_back(e);
		endfunction

		function void note_pixel(logic [PIX_W-1:0] p);
			int w, h, r, c;
			int g [4];
			int neg, pos;
			w = clamp_size(width_reg, MAXW);
			h = clamp_size(height_reg, MAXH);
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
			end
			if (row_pos >= h) row_pos = 0;
			r = row_pos;
			c = col_pos;
			lines[r % 3][c] = p;
			if (r >= 1 && c >= 1) begin
				foreach (g[i]) g[i] = 0;
				if (c == 1) foreach (row_sums[i]) row_sums[i] = '0;
				if (r >= 2 && c >= 2) begin
					g[0] = pix(r-1, c) - pix(r-1, c-2);
					g[1] = pix(r, c-1) - pix(r-2, c-1);
					g[2] = pix(r-2, c) - pix(r, c-2);
					g[3] = pix(r, c) - pix(r-2, c-2);
				end
				for (int i = 0; i < 4; i++) begin
					neg = g[i] < 0 ? -2 * g[i] : 0;
					pos = g[i] > 0 ? 2 * g[i] : 0;
					row_sums[2*i] = row_sums[2*i] + RSUM_W'(neg);
					row_sums[2*i+1] = row_sums[2*i+1] + RSUM_W'(pos);
				end
				post_entry(r, c, c != w - 1);
				if (c == w - 1) post_entry(r, w, 1'b1);
			end
			col_pos = c + 1;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos = r + 1;
				if (row_pos >= h) row_pos = 0;
			end
		endfunction

		function void check_entry(entry_t got);
			entry_t want;
			if (pending_entries.size() == 0) begin
				$display("%0t: unexpected item row %0d col %0d", $time, got.row, got.col);
				errors++;
				return;
			end
			want = pending_entries.pop_front();
			for (int ch = 0; ch < NCH; ch++)
				if (got.sums[ch] !== want.sums[ch]) begin
					$display("%0t: channel %0d at (%0d,%0d) expected %0d got %0d", $time,
						ch, want.row, want.col, want.sums[ch], got.sums[ch]);
					errors++;
				end
			if (got.row !== want.row || got.col !== want.col) begin
				$display("%0t: position expected (%0d,%0d) got (%0d,%0d)", $time,
					want.row, want.col, got.row, got.col);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last_of_step expected %0b got %0b", $time, want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [PIX_W-1:0] pixel;
	logic out_valid;
	logic out_stall;
	logic [OUT_W-1:0] sum_neg_dx, sum_pos_dx, sum_neg_dy, sum_pos_dy;
	logic [OUT_W-1:0] sum_neg_du, sum_pos_du, sum_neg_dv, sum_pos_dv;
	logic [ROW_OUT_W-1:0] out_row;
	logic [COL_OUT_W-1:0] out_col;
	logic last_of_step;

	grad_integral_scoreboard sb;
	bit idle_en;

	oriented_gradient_integral_image u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .pixel(pixel),
		.out_valid(out_valid), .out_stall(out_stall),
		.sum_neg_dx(sum_neg_dx), .sum_pos_dx(sum_pos_dx),
		.sum_neg_dy(sum_neg_dy), .sum_pos_dy(sum_pos_dy),
		.sum_neg_du(sum_neg_du), .sum_pos_du(sum_pos_du),
		.sum_neg_dv(sum_neg_dv), .sum_pos_dv(sum_pos_dv),
		.out_row(out_row), .out_col(out_col), .last_of_step(last_of_step)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_oriented_gradient_integral_image NOT OK");
		$finish;
	end

	// receiver side: random stall bursts while idling is on
	initial begin
		out_stall = 1'b0;
		forever begin
			if (idle_en && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		entry_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.sums = {sum_pos_dv, sum_neg_dv, sum_pos_du, sum_neg_du,
				sum_pos_dy, sum_neg_dy, sum_pos_dx, sum_neg_dx};
			got.row = out_row;
			got.col = out_col;
			got.last = last_of_step;
			sb.check_entry(got);
		end
	end

	task automatic send_pixel(input logic [PIX_W-1:0] p);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (in_stall);
		sb.note_pixel(p);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending_entries.size() != 0) @(posedge clk);
		// row-start pixels produce nothing but may still be in flight
		repeat (4) @(posedge clk);
	endtask

	task automatic write_size(input int w, input int h);
		// a wider row needs every line store filled, so finish the image first
		if (sb.clamp_size(w & 9'h1ff, MAXW) > sb.cur_width())
			while (sb.row_pos != 0 || sb.col_pos != 0) send_pixel($urandom_range(0, 255));
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data <= CFG_W'(w);
		@(posedge clk);
		sb.width_reg = CFG_W'(w);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_data <= CFG_W'(h);
		@(posedge clk);
		sb.height_reg = CFG_W'(h);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int rand_size();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(1, 2);
			2: return $urandom_range(257, 511);
			3: return 256;
			default: return $urandom_range(3, 12);
		endcase
	endfunction

	task automatic run_pixels(input int n);
		repeat (n) send_pixel(rand_pixel());
	endtask

	initial begin
		logic [PIX_W-1:0] pat [9];
		int w, h;
		pat = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd0, 8'd255};
		sb = new();
		idle_en = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_IMAGE_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest image, checkerboard then its inverse, then a second image wrap
		write_size(3, 3);
		foreach (pat[i]) send_pixel(pat[i]);
		foreach (pat[i]) send_pixel(~pat[i]);
		write_size(511, 511);
		send_pixel(8'd255);
		send_pixel(8'd0);
		write_size(3, 3);

		idle_en = 1'b1;
		write_size(256, 3);
		run_pixels(260);
		write_size(2, 12);
		run_pixels(30);
		write_size(5, 1);
		run_pixels(20);
		for (int ph = 0; ph < 4; ph++) begin
			w = rand_size();
			h = rand_size();
			// keep images small so that finishing one stays short
			if (sb.clamp_size(w, MAXW) * sb.clamp_size(h, MAXH) > 40) begin
				w = 8;
				h = 5;
			end
			write_size(w, h);
			run_pixels($urandom_range(8, 20));
			// shrink mid-image
			if ($urandom_range(0, 1)) begin
				write_size(3, $urandom_range(0, 6));
				run_pixels(6);
			end
		end

		idle_en = 1'b0;
		write_size(6, 4);
		run_pixels(24);
		in_valid <= 1'b0;
		while (sb.pending_entries.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_oriented_gradient_integral_image OK");
		else
			$display("tb_oriented_gradient_integral_image NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
